### design/cwfs_pkg.sv
// Shared types and constants for the CW frequency sweep sequencer.
// Used by cwfs_exec and cw_frequency_sweep_sequencer_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwfs_pkg;

    // Width of the running frequency: covers start plus two whole steps
    localparam int CUR_W = 35;

    typedef enum logic [2:0] {
        OP_START       = 3'd0,
        OP_LOAD_SCHED  = 3'd1,
        OP_LOAD_DONE   = 3'd2,
        OP_CORR_DONE   = 3'd3,
        OP_READ_POINT  = 3'd4,
        OP_STATUS      = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_LOADING   = 3'd1,
        MODE_LOAD_DONE = 3'd2,
        MODE_RUNNING   = 3'd3,
        MODE_RUN_DONE  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ACT_WRITE_FREQ   = 3'd0,
        ACT_DISABLE_CHAN = 3'd1,
        ACT_ENABLE_LOAD  = 3'd2,
        ACT_STROBE       = 3'd3,
        ACT_DISABLE_LOAD = 3'd4,
        ACT_REPORT_POINT = 3'd5,
        ACT_SPECTRUM     = 3'd6,
        ACT_STATUS       = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        CFG_START = 2'd0,
        CFG_STOP  = 2'd1,
        CFG_STEP  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] stop;
        logic [30:0] step;
    } t_cfg;

    // One result word
    typedef struct packed {
        t_action     action;
        logic [31:0] freq;
        logic [31:0] strobe;
        logic [63:0] power;
        logic        load_done;
        logic        sweep_done;
        logic        last;
    } t_result;

    // Item as it enters the execute stage
    typedef struct packed {
        logic        valid;
        t_op         op;
        logic [31:0] strobe;
        logic [63:0] sq_i;
        logic [63:0] sq_q;
        logic        idx_ok;
        logic [63:0] rd_power;
    } t_exec_in;

    // Words produced by the execute stage in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_exec_out;

    function automatic t_result mk_result(t_action act, logic [31:0] freq,
                                          logic [31:0] strobe, logic [63:0] power,
                                          logic ld, logic sd);
        t_result r;
        r.action     = act;
        r.freq       = freq;
        r.strobe     = strobe;
        r.power      = power;
        r.load_done  = ld;
        r.sweep_done = sd;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

### design/cwfs_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cwfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/cwfs_exec.sv
// Execute stage of the sweep sequencer: mode, frequency and point count state,
// power store write and result word generation. Depends on cwfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cwfs_exec #(
    parameter int STORE_DEPTH = 256,
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cwfs_pkg::t_cfg      i_cfg,
    input  wire cwfs_pkg::t_exec_in  i_item,
    output cwfs_pkg::t_exec_out      o_out,
    output logic                     o_mem_we,
    output logic [AW-1:0]            o_mem_waddr,
    output logic [63:0]              o_mem_wdata
);

    localparam int W = cwfs_pkg::CUR_W;

    cwfs_pkg::t_mode         r_mode, n_mode;
    logic signed [W-1:0]     r_cur_freq, n_cur_freq;
    logic [15:0]             r_point_count, n_point_count;

    logic signed [W-1:0]     w_step;
    logic signed [W-1:0]     w_stop;
    logic signed [W-1:0]     w_start;
    logic signed [W-1:0]     w_stop_plus;
    logic signed [W-1:0]     w_freq_inc;
    logic signed [W-1:0]     w_freq_next;
    logic [63:0]             w_power;
    logic                    w_pc_in_range;
    cwfs_pkg::t_result       w_tail;
    cwfs_pkg::t_exec_out     w_out;

    // Operands widened so every sum and compare is exact
    assign w_step      = $signed({{(W-31){1'b0}}, i_cfg.step});
    assign w_stop      = $signed({{(W-32){i_cfg.stop[31]}}, i_cfg.stop});
    assign w_start     = $signed({{(W-32){i_cfg.start[31]}}, i_cfg.start});
    assign w_stop_plus = w_stop + w_step;
    assign w_freq_inc  = r_cur_freq + w_step;
    assign w_freq_next = w_freq_inc + w_step;
    assign w_power     = i_item.sq_i + i_item.sq_q;
    assign w_pc_in_range = 32'(r_point_count) < STORE_DEPTH;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cwfs_pkg::MODE_IDLE;
            r_cur_freq    <= '0;
            r_point_count <= '0;
        end else begin
            r_mode        <= n_mode;
            r_cur_freq    <= n_cur_freq;
            r_point_count <= n_point_count;
        end
    end

    // Next state and result words
    always_comb begin
        n_mode        = r_mode;
        n_cur_freq    = r_cur_freq;
        n_point_count = r_point_count;
        o_mem_we      = 1'b0;
        o_mem_waddr   = r_point_count[AW-1:0];
        o_mem_wdata   = w_power;
        w_tail        = cwfs_pkg::mk_result(cwfs_pkg::ACT_DISABLE_CHAN, '0, '0, '0,
                                            1'b0, 1'b0);
        w_out.cnt     = 2'd0;
        w_out.res0    = w_tail;
        w_out.res1    = w_tail;
        if (i_item.valid) begin
            unique case (i_item.op)
                cwfs_pkg::OP_START: begin
                    n_mode        = cwfs_pkg::MODE_RUNNING;
                    n_point_count = '0;
                    n_cur_freq    = w_start;
                    w_out.cnt  = 2'd2;
                    w_out.res0 = cwfs_pkg::mk_result(cwfs_pkg::ACT_WRITE_FREQ,
                                                     w_start[31:0], '0, '0, 1'b0, 1'b0);
                    w_out.res1 = cwfs_pkg::mk_result(cwfs_pkg::ACT_WRITE_FREQ,
                                                     i_cfg.start + {1'b0, i_cfg.step},
                                                     '0, '0, 1'b0, 1'b0);
                end
                cwfs_pkg::OP_LOAD_SCHED: begin
                    n_mode     = cwfs_pkg::MODE_LOADING;
                    w_out.cnt  = 2'd2;
                    w_out.res0 = cwfs_pkg::mk_result(cwfs_pkg::ACT_ENABLE_LOAD,
                                                     '0, '0, '0, 1'b0, 1'b0);
                    w_out.res1 = cwfs_pkg::mk_result(cwfs_pkg::ACT_STROBE, '0,
                                                     i_item.strobe, '0, 1'b0, 1'b0);
                end
                cwfs_pkg::OP_LOAD_DONE: begin
                    n_mode     = cwfs_pkg::MODE_LOAD_DONE;
                    w_out.cnt  = 2'd1;
                    w_out.res0 = cwfs_pkg::mk_result(cwfs_pkg::ACT_DISABLE_LOAD,
                                                     '0, '0, '0, 1'b0, 1'b0);
                end
                cwfs_pkg::OP_CORR_DONE: begin
                    if (r_mode != cwfs_pkg::MODE_RUNNING) begin
                        w_out.cnt = 2'd1;
                    end else begin
                        // advance the sweep and pick the follow-up command
                        n_cur_freq = w_freq_inc;
                        if (r_point_count != 16'hFFFF) begin
                            n_point_count = r_point_count + 16'd1;
                        end
                        if (w_freq_inc >= w_stop_plus) begin
                            n_mode = cwfs_pkg::MODE_RUN_DONE;
                        end else if (w_freq_inc < w_stop) begin
                            w_tail = cwfs_pkg::mk_result(cwfs_pkg::ACT_WRITE_FREQ,
                                                         w_freq_next[31:0], '0, '0,
                                                         1'b0, 1'b0);
                        end
                        // store and report while the store has room
                        if (w_pc_in_range) begin
                            o_mem_we   = 1'b1;
                            w_out.cnt  = 2'd2;
                            w_out.res0 = cwfs_pkg::mk_result(cwfs_pkg::ACT_REPORT_POINT,
                                                             r_cur_freq[31:0], '0,
                                                             w_power, 1'b0, 1'b0);
                            w_out.res1 = w_tail;
                        end else begin
                            w_out.cnt  = 2'd1;
                            w_out.res0 = w_tail;
                        end
                    end
                end
                cwfs_pkg::OP_READ_POINT: begin
                    w_out.cnt  = 2'd1;
                    w_out.res0 = cwfs_pkg::mk_result(cwfs_pkg::ACT_SPECTRUM, '0, '0,
                                                     i_item.idx_ok ? i_item.rd_power
                                                                   : 64'd0,
                                                     1'b0, 1'b0);
                end
                cwfs_pkg::OP_STATUS: begin
                    w_out.cnt  = 2'd1;
                    w_out.res0 = cwfs_pkg::mk_result(
                        cwfs_pkg::ACT_STATUS, '0, '0, '0,
                        r_mode == cwfs_pkg::MODE_LOAD_DONE,
                        r_mode == cwfs_pkg::MODE_RUN_DONE);
                end
                default: begin
                    w_out.cnt = 2'd0;
                end
            endcase
        end
        // mark the final word of the item
        if (w_out.cnt == 2'd2) begin
            w_out.res1.last = 1'b1;
        end else begin
            w_out.res0.last = 1'b1;
        end
        o_out = w_out;
    end

endmodule

`default_nettype wire

### design/cw_frequency_sweep_sequencer_top.sv
// Top level of the CW frequency sweep sequencer: input and multiply stages,
// configuration registers and result queue. Depends on cwfs_pkg, cwfs_ram, cwfs_exec.
`timescale 1ns / 1ps
`default_nettype none

// An event word passes an input register, a squaring stage (two 32x32 multipliers
// in parallel) and an execute stage that updates the sweep state and emits up to
// two result words into an eight-entry queue. A new event word is taken every
// cycle while the queue has room for the words of all events in flight; results
// leave one per cycle while i_stall is low, so the output port sets the sustained
// rate. The power store is a RAM of STORE_DEPTH 64-bit entries read one stage
// ahead of execute, with a bypass for a write in the same cycle. Entries never
// written read back as unknown data. Configuration is taken on any cycle with the
// write enable high and should change only while idle.
module cw_frequency_sweep_sequencer_top #(
    parameter int STORE_DEPTH = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_wr_en,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_wdata,
    // event words
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [2:0]         i_op,
    input  wire logic [31:0]        i_strobe_count,
    input  wire logic signed [31:0] i_corr_i,
    input  wire logic signed [31:0] i_corr_q,
    input  wire logic [15:0]        i_point_index,
    // result words
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [2:0]              o_action,
    output logic signed [31:0]      o_freq_value,
    output logic [31:0]             o_strobe_time,
    output logic [63:0]             o_power_value,
    output logic                    o_load_done_flag,
    output logic                    o_sweep_done_flag,
    output logic                    o_last
);

    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);

    cwfs_pkg::t_cfg        r_cfg;
    logic                  w_accept;

    // input stage
    logic                  r_s0_valid;
    cwfs_pkg::t_op         r_s0_op;
    logic [31:0]           r_s0_strobe;
    logic [31:0]           r_s0_abs_i;
    logic [31:0]           r_s0_abs_q;
    logic [15:0]           r_s0_idx;
    logic                  r_s0_idx_ok;

    // squaring stage
    logic                  r_s1_valid;
    cwfs_pkg::t_op         r_s1_op;
    logic [31:0]           r_s1_strobe;
    logic [63:0]           r_s1_sq_i;
    logic [63:0]           r_s1_sq_q;
    logic                  r_s1_idx_ok;
    logic                  r_byp_hit;
    logic [63:0]           r_byp_data;

    // power store
    logic                  w_mem_re;
    logic                  w_mem_we;
    logic [AW-1:0]         w_mem_waddr;
    logic [63:0]           w_mem_wdata;
    logic [63:0]           w_mem_rdata;

    cwfs_pkg::t_exec_in    w_exec_in;
    cwfs_pkg::t_exec_out   w_exec_out;

    // result queue
    cwfs_pkg::t_result     r_q [QDEPTH];
    logic [QAW-1:0]        r_q_wp;
    logic [QAW-1:0]        r_q_rp;
    logic [QAW:0]          r_q_count;
    logic                  w_pop;
    logic [QAW+1:0]        w_commit;
    cwfs_pkg::t_result     w_head;

    // Hold off new words unless the queue can take two words per event in flight
    assign w_commit = {1'b0, r_q_count}
                    + (QAW+2)'({r_s0_valid, 1'b0})
                    + (QAW+2)'({r_s1_valid, 1'b0});
    assign o_stall  = !i_rst_n || (w_commit > (QAW+2)'(QDEPTH - 2));
    assign w_accept = i_valid && !o_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start <= '0;
            r_cfg.stop  <= '0;
            r_cfg.step  <= 31'd1;
        end else if (i_cfg_wr_en) begin
            unique case (cwfs_pkg::t_cfg_reg'(i_cfg_index))
                cwfs_pkg::CFG_START: r_cfg.start <= i_cfg_wdata;
                cwfs_pkg::CFG_STOP:  r_cfg.stop  <= i_cfg_wdata;
                cwfs_pkg::CFG_STEP:  r_cfg.step  <= i_cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    // Stage valids: the pipeline never stalls internally
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s0_valid <= w_accept;
            r_s1_valid <= r_s0_valid;
        end
    end

    // Capture the word and take magnitudes of the correlation values
    always_ff @(posedge i_clk) begin
        r_s0_op     <= cwfs_pkg::t_op'(i_op);
        r_s0_strobe <= i_strobe_count;
        r_s0_abs_i  <= i_corr_i[31] ? (~i_corr_i + 32'd1) : i_corr_i;
        r_s0_abs_q  <= i_corr_q[31] ? (~i_corr_q + 32'd1) : i_corr_q;
        r_s0_idx    <= i_point_index;
        r_s0_idx_ok <= 32'(i_point_index) < STORE_DEPTH;
    end

    // Square both magnitudes; catch a store write to the address being read
    always_ff @(posedge i_clk) begin
        r_s1_op     <= r_s0_op;
        r_s1_strobe <= r_s0_strobe;
        r_s1_sq_i   <= r_s0_abs_i * r_s0_abs_i;
        r_s1_sq_q   <= r_s0_abs_q * r_s0_abs_q;
        r_s1_idx_ok <= r_s0_idx_ok;
        r_byp_hit   <= w_mem_we && (w_mem_waddr == r_s0_idx[AW-1:0]);
        r_byp_data  <= w_mem_wdata;
    end

    assign w_mem_re = r_s0_valid && (r_s0_op == cwfs_pkg::OP_READ_POINT);

    cwfs_ram #(
        .WIDTH (64),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_s0_idx[AW-1:0]),
        .o_rdata (w_mem_rdata)
    );

    assign w_exec_in.valid    = r_s1_valid;
    assign w_exec_in.op       = r_s1_op;
    assign w_exec_in.strobe   = r_s1_strobe;
    assign w_exec_in.sq_i     = r_s1_sq_i;
    assign w_exec_in.sq_q     = r_s1_sq_q;
    assign w_exec_in.idx_ok   = r_s1_idx_ok;
    assign w_exec_in.rd_power = r_byp_hit ? r_byp_data : w_mem_rdata;

    cwfs_exec #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (w_exec_in),
        .o_out       (w_exec_out),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata)
    );

    // Result queue: push up to two words, pop one
    assign w_pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp    <= '0;
            r_q_rp    <= '0;
            r_q_count <= '0;
        end else begin
            r_q_wp    <= r_q_wp + QAW'(w_exec_out.cnt);
            r_q_rp    <= r_q_rp + QAW'(w_pop);
            r_q_count <= r_q_count + (QAW+1)'(w_exec_out.cnt) - (QAW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_out.cnt != 2'd0) begin
            r_q[r_q_wp] <= w_exec_out.res0;
        end
        if (w_exec_out.cnt == 2'd2) begin
            r_q[r_q_wp + QAW'(1)] <= w_exec_out.res1;
        end
    end

    assign w_head            = r_q[r_q_rp];
    assign o_valid           = r_q_count != '0;
    assign o_action          = w_head.action;
    assign o_freq_value      = $signed(w_head.freq);
    assign o_strobe_time     = w_head.strobe;
    assign o_power_value     = w_head.power;
    assign o_load_done_flag  = w_head.load_done;
    assign o_sweep_done_flag = w_head.sweep_done;
    assign o_last            = w_head.last;

    // The queue never overfills
    a_queue_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");

    // Result words only come from an event in the execute stage
    a_words_need_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> (w_exec_out.cnt == 2'd0))
        else $error("result words without an event");

    // The store is written only by a correlation event in execute
    a_store_write : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_s1_valid && r_s1_op == cwfs_pkg::OP_CORR_DONE))
        else $error("unexpected power store write");

    // An accepted word enters the input stage
    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_s0_valid)
        else $error("accepted word lost");

endmodule

`default_nettype wire
